[src/ipsw_pkg.sv]
// shared types and codes for the interrupt profiler with sampling watchdog
// no dependencies
`default_nettype none

package ipsw_pkg;

    localparam logic [1:0] ACT_IRQ   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [1:0] TACT_NONE  = 2'd0;
    localparam logic [1:0] TACT_REARM = 2'd1;
    localparam logic [1:0] TACT_SHUT  = 2'd2;
    localparam logic [1:0] TACT_FIRE  = 2'd3;

    localparam logic [1:0] CFG_MODE     = 2'd0;
    localparam logic [1:0] CFG_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_INTERVAL = 2'd2;

    localparam logic [9:0] ID_SGI0     = 10'h000;
    localparam logic [9:0] ID_TIMER_A  = 10'd18;
    localparam logic [9:0] ID_TIMER_B  = 10'd19;
    localparam logic [9:0] ID_SPURIOUS = 10'h3ff;

    localparam logic [2:0] TCTL_RESET = 3'b111;

    typedef struct packed {
        logic [1:0]  kind;
        logic        is_sgi;
        logic        is_timer;
        logic        is_spur;
        logic [31:0] pc;
        logic [2:0]  tctl;
        logic [3:0]  ridx;
    } t_item;

    typedef struct packed {
        logic        mode;
        logic [31:0] limit;
        logic [31:0] interval;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  timer_action;
        logic        send_eoi;
        logic [31:0] rearm_ticks;
        logic [31:0] total_count;
        logic [31:0] sgi_count;
        logic [31:0] timer_irq_count;
        logic [31:0] spurious_count;
        logic [31:0] other_count;
        logic [31:0] budget_used;
        logic        watchdog_fired;
        logic [31:0] ring_word;
        logic [2:0]  last_timer_ctrl;
    } t_result;

endpackage

`default_nettype wire

[src/ipsw_front.sv]
// front end: decodes the interrupt id and classifies each incoming item
// depends on ipsw_pkg
`default_nettype none

module ipsw_front (
    input  wire logic [1:0]     i_action,
    input  wire logic [31:0]    i_ack_word,
    input  wire logic [31:0]    i_sampled_pc,
    input  wire logic [2:0]     i_timer_ctrl,
    input  wire logic [3:0]     i_read_index,
    output ipsw_pkg::t_item     o_item
);

    logic [9:0] w_id;

    assign w_id = i_ack_word[9:0];

    always_comb begin
        o_item.kind     = i_action;
        o_item.is_sgi   = (w_id == ipsw_pkg::ID_SGI0);
        o_item.is_timer = (w_id == ipsw_pkg::ID_TIMER_A) || (w_id == ipsw_pkg::ID_TIMER_B);
        o_item.is_spur  = (w_id == ipsw_pkg::ID_SPURIOUS);
        o_item.pc       = i_sampled_pc;
        o_item.tctl     = i_timer_ctrl;
        o_item.ridx     = i_read_index;
    end

endmodule

`default_nettype wire

[src/ipsw_fifo.sv]
// two-entry queue between the front end and the execution back end
// depends on ipsw_pkg
`default_nettype none

module ipsw_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ipsw_pkg::t_item i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output ipsw_pkg::t_item     o_item
);

    ipsw_pkg::t_item r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_count;
    logic [1:0]      n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item  = r_mem[r_rp];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

[src/ipsw_back.sv]
// back end: counters, pc ring, sampling budget and the result register
// depends on ipsw_pkg
`default_nettype none

module ipsw_back #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ipsw_pkg::t_cfg i_cfg,
    input  wire logic           i_empty,
    input  wire ipsw_pkg::t_item i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output ipsw_pkg::t_result   o_result
);

    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int CMP_W   = ((RING_AW > 4) ? RING_AW : 4) + 1;

    logic [31:0]        r_ring [RING_DEPTH];
    logic [31:0]        r_rd_data;
    logic               r_rd_ok;
    logic [RING_AW-1:0] r_slot;
    logic               r_full;
    logic [31:0]        r_total;
    logic [31:0]        r_sgi;
    logic [31:0]        r_timer;
    logic [31:0]        r_spur;
    logic [31:0]        r_other;
    logic [31:0]        r_budget;
    logic               r_fired;
    logic [2:0]         r_tctl;
    logic               r_valid;
    logic [1:0]         r_tact;
    logic               r_eoi;
    logic [31:0]        r_ticks;

    logic [31:0]        w_budget_inc;
    logic [CMP_W-1:0]   w_ridx;
    logic [CMP_W-1:0]   w_slot;
    logic [RING_AW-1:0] w_rd_addr;
    logic               w_rd_ok;
    logic               w_irq;
    logic               w_read;
    logic               w_clear;
    logic               w_wrap;

    assign o_pop   = !i_empty && (!r_valid || i_ready);
    assign w_irq   = o_pop && (i_item.kind == ipsw_pkg::ACT_IRQ);
    assign w_clear = o_pop && (i_item.kind == ipsw_pkg::ACT_CLEAR);
    assign w_read  = o_pop && (i_item.kind == ipsw_pkg::ACT_READ);

    assign w_budget_inc = r_budget + 32'd1;
    assign w_ridx       = CMP_W'(i_item.ridx);
    assign w_slot       = CMP_W'(r_slot);
    assign w_rd_addr    = w_ridx[RING_AW-1:0];
    assign w_rd_ok      = (w_ridx < CMP_W'(RING_DEPTH)) && (r_full || (w_ridx < w_slot));
    assign w_wrap       = (r_slot == RING_AW'(RING_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_slot   <= '0;
            r_full   <= 1'b0;
            r_total  <= '0;
            r_sgi    <= '0;
            r_timer  <= '0;
            r_spur   <= '0;
            r_other  <= '0;
            r_budget <= '0;
            r_fired  <= 1'b0;
            r_tctl   <= ipsw_pkg::TCTL_RESET;
            r_rd_ok  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_rd_ok <= w_read && w_rd_ok;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (w_clear) begin
                r_slot   <= '0;
                r_full   <= 1'b0;
                r_total  <= '0;
                r_sgi    <= '0;
                r_timer  <= '0;
                r_spur   <= '0;
                r_other  <= '0;
                r_budget <= '0;
                r_fired  <= 1'b0;
                r_tctl   <= ipsw_pkg::TCTL_RESET;
            end else if (w_irq) begin
                r_total <= r_total + 32'd1;
                if (w_wrap || (r_total == 32'hffff_ffff)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + RING_AW'(1);
                end
                if (w_wrap) begin
                    r_full <= 1'b1;
                end
                if (i_item.is_sgi) begin
                    r_sgi <= r_sgi + 32'd1;
                end else if (i_item.is_timer) begin
                    r_timer <= r_timer + 32'd1;
                    r_tctl  <= i_item.tctl;
                    if (i_cfg.mode) begin
                        r_budget <= w_budget_inc;
                        if (!(w_budget_inc < i_cfg.limit)) begin
                            r_fired <= 1'b1;
                        end
                    end
                end else if (i_item.is_spur) begin
                    r_spur <= r_spur + 32'd1;
                end else begin
                    r_other <= r_other + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tact  <= ipsw_pkg::TACT_NONE;
            r_ticks <= '0;
            r_eoi   <= w_irq && !i_item.is_spur;
            if (w_irq && i_item.is_timer) begin
                if (!i_cfg.mode) begin
                    r_tact <= ipsw_pkg::TACT_SHUT;
                end else if (w_budget_inc < i_cfg.limit) begin
                    r_tact  <= ipsw_pkg::TACT_REARM;
                    r_ticks <= i_cfg.interval;
                end else begin
                    r_tact <= ipsw_pkg::TACT_FIRE;
                end
            end
        end
    end

    // ring memory, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_irq) begin
            r_ring[r_slot] <= i_item.pc;
        end
        if (w_read) begin
            r_rd_data <= r_ring[w_rd_addr];
        end
    end

    assign o_valid = r_valid;

    always_comb begin
        o_result.timer_action    = r_tact;
        o_result.send_eoi        = r_eoi;
        o_result.rearm_ticks     = r_ticks;
        o_result.total_count     = r_total;
        o_result.sgi_count       = r_sgi;
        o_result.timer_irq_count = r_timer;
        o_result.spurious_count  = r_spur;
        o_result.other_count     = r_other;
        o_result.budget_used     = r_budget;
        o_result.watchdog_fired  = r_fired;
        o_result.ring_word       = r_rd_ok ? r_rd_data : 32'd0;
        o_result.last_timer_ctrl = r_tctl;
    end

endmodule

`default_nettype wire

[src/irq_pc_sampling_watchdog.sv]
// interrupt profiler with pc sampling ring and sampling-budget watchdog
// top level; depends on ipsw_pkg, ipsw_front, ipsw_fifo, ipsw_back
`default_nettype none

// Takes one item per cycle while the output is not stalled and returns one
// result per item; each item passes the front queue register, then the back
// end result register. Counter and budget state is updated in the back end,
// so throughput is one item per clock unless the result channel stalls. The pc
// ring is a RING_DEPTH-entry memory with one write and one registered read
// port; entries not yet written since reset or clear read as zero through a
// fill count, so no clearing pass is needed on a clear.
// The config port is always ready; write it only when no item is in flight.
module irq_pc_sampling_watchdog #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [1:0]     i_cfg_index,
    input  wire logic [31:0]    i_cfg_data,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    // ack_word, sampled_pc, timer_ctrl, read_index, zero pad
    input  wire logic [71:0]    i_s_tdata,
    // action
    input  wire logic [1:0]     i_s_tuser,
    output logic                o_m_tvalid,
    input  wire logic           i_m_tready,
    // timer_action, send_eoi, rearm_ticks, total_count, sgi_count, timer_irq_count,
    // spurious_count, other_count, budget_used, watchdog_fired, ring_word,
    // last_timer_ctrl, zero pad
    output logic [263:0]        o_m_tdata
);

    ipsw_pkg::t_cfg    r_cfg;
    ipsw_pkg::t_item   w_front_item;
    ipsw_pkg::t_item   w_q_item;
    ipsw_pkg::t_result w_result;
    logic              w_full;
    logic              w_empty;
    logic              w_pop;
    logic              w_push;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ipsw_pkg::CFG_MODE:     r_cfg.mode     <= i_cfg_data[0];
                ipsw_pkg::CFG_LIMIT:    r_cfg.limit    <= i_cfg_data;
                ipsw_pkg::CFG_INTERVAL: r_cfg.interval <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ipsw_front u_front (
        .i_action     (i_s_tuser),
        .i_ack_word   (i_s_tdata[31:0]),
        .i_sampled_pc (i_s_tdata[63:32]),
        .i_timer_ctrl (i_s_tdata[66:64]),
        .i_read_index (i_s_tdata[70:67]),
        .o_item       (w_front_item)
    );

    assign o_s_tready = !w_full;
    assign w_push     = i_s_tvalid && !w_full;

    ipsw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_q_item)
    );

    ipsw_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (w_empty),
        .i_item   (w_q_item),
        .o_pop    (w_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (w_result)
    );

    assign o_m_tdata = {1'b0,
                        w_result.last_timer_ctrl,
                        w_result.ring_word,
                        w_result.watchdog_fired,
                        w_result.budget_used,
                        w_result.other_count,
                        w_result.spurious_count,
                        w_result.timer_irq_count,
                        w_result.sgi_count,
                        w_result.total_count,
                        w_result.rearm_ticks,
                        w_result.send_eoi,
                        w_result.timer_action};

endmodule

`default_nettype wire

[tb/sv/irq_pc_sampling_watchdog_chk.sv]
// checker for the interrupt profiler: watches the config, input and result channels,
// predicts every result and compares it field by field
// depends on ipsw_pkg for codes and the result struct
`default_nettype none

module irq_pc_sampling_watchdog_chk #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_valid,
    input  wire logic           i_cfg_ready,
    input  wire logic [1:0]     i_cfg_index,
    input  wire logic [31:0]    i_cfg_data,
    input  wire logic           i_s_tvalid,
    input  wire logic           i_s_tready,
    input  wire logic [71:0]    i_s_tdata,
    input  wire logic [1:0]     i_s_tuser,
    input  wire logic           i_m_tvalid,
    input  wire logic           i_m_tready,
    input  wire logic [263:0]   i_m_tdata,
    output int                  o_fail_count,
    output int                  o_outstanding,
    output int                  o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import ipsw_pkg::*;

    logic [31:0] pc_log [RING_DEPTH];
    logic [31:0] n_irq, n_sgi, n_timer, n_spur, n_other, n_budget;
    logic        fired;
    logic [2:0]  tctl_seen;
    logic        cfg_mode;
    logic [31:0] cfg_limit, cfg_interval;
    t_result     expected_reports[$];
    t_result     want;
    int          fails = 0;
    int          checked = 0;
    int          pending = 0;

    assign o_fail_count  = fails;
    assign o_outstanding = pending;
    assign o_checked     = checked;

    function automatic void clear_profile();
        for (int i = 0; i < RING_DEPTH; i++) begin
            pc_log[i] = '0;
        end
        n_irq     = '0;
        n_sgi     = '0;
        n_timer   = '0;
        n_spur    = '0;
        n_other   = '0;
        n_budget  = '0;
        fired     = 1'b0;
        tctl_seen = TCTL_RESET;
    endfunction

    function automatic t_result step_profile(input logic [1:0] act, input logic [31:0] ack,
                                             input logic [31:0] pc, input logic [2:0] tctl,
                                             input logic [3:0] ridx);
        t_result    r;
        logic [9:0] irq_id;
        r = '0;
        irq_id = ack[9:0];
        case (act)
            ACT_IRQ: begin
                pc_log[n_irq % RING_DEPTH] = pc;
                n_irq++;
                if (irq_id == ID_SGI0) begin
                    n_sgi++;
                end else if (irq_id == ID_TIMER_A || irq_id == ID_TIMER_B) begin
                    n_timer++;
                    tctl_seen = tctl;
                    if (cfg_mode) begin
                        n_budget++;
                        if (n_budget < cfg_limit) begin
                            r.timer_action = TACT_REARM;
                            r.rearm_ticks  = cfg_interval;
                        end else begin
                            fired          = 1'b1;
                            r.timer_action = TACT_FIRE;
                        end
                    end else begin
                        r.timer_action = TACT_SHUT;
                    end
                end else if (irq_id == ID_SPURIOUS) begin
                    n_spur++;
                end else begin
                    n_other++;
                end
                r.send_eoi = (irq_id != ID_SPURIOUS);
            end
            ACT_CLEAR: begin
                clear_profile();
            end
            ACT_READ: begin
                if (ridx < RING_DEPTH) begin
                    r.ring_word = pc_log[ridx];
                end
            end
            default: ;
        endcase
        r.total_count     = n_irq;
        r.sgi_count       = n_sgi;
        r.timer_irq_count = n_timer;
        r.spurious_count  = n_spur;
        r.other_count     = n_other;
        r.budget_used     = n_budget;
        r.watchdog_fired  = fired;
        r.last_timer_ctrl = tctl_seen;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_profile();
            cfg_mode     = 1'b0;
            cfg_limit    = '0;
            cfg_interval = '0;
            expected_reports.delete();
            pending      = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MODE:     cfg_mode     = i_cfg_data[0];
                    CFG_LIMIT:    cfg_limit    = i_cfg_data;
                    CFG_INTERVAL: cfg_interval = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_reports.push_back(step_profile(i_s_tuser, i_s_tdata[31:0],
                    i_s_tdata[63:32], i_s_tdata[66:64], i_s_tdata[70:67]));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: result with no item pending, expected none, actual %h",
                             $time, i_m_tdata);
                    fails++;
                end else begin
                    want = expected_reports.pop_front();
                    checked++;
                    check_field("timer_action", 32'(want.timer_action), 32'(i_m_tdata[1:0]));
                    check_field("send_eoi", 32'(want.send_eoi), 32'(i_m_tdata[2]));
                    check_field("rearm_ticks", want.rearm_ticks, i_m_tdata[34:3]);
                    check_field("total_count", want.total_count, i_m_tdata[66:35]);
                    check_field("sgi_count", want.sgi_count, i_m_tdata[98:67]);
                    check_field("timer_irq_count", want.timer_irq_count, i_m_tdata[130:99]);
                    check_field("spurious_count", want.spurious_count, i_m_tdata[162:131]);
                    check_field("other_count", want.other_count, i_m_tdata[194:163]);
                    check_field("budget_used", want.budget_used, i_m_tdata[226:195]);
                    check_field("watchdog_fired", 32'(want.watchdog_fired),
                                32'(i_m_tdata[227]));
                    check_field("ring_word", want.ring_word, i_m_tdata[259:228]);
                    check_field("last_timer_ctrl", 32'(want.last_timer_ctrl),
                                32'(i_m_tdata[262:260]));
                end
            end
            pending = expected_reports.size();
        end
    end

endmodule

`default_nettype wire

[tb/sv/irq_pc_sampling_watchdog_tb.sv]
// testbench top for the interrupt profiler: clock, reset, config writes and
// directed plus random items with random pacing on both channels
// depends on ipsw_pkg, irq_pc_sampling_watchdog and irq_pc_sampling_watchdog_chk
`default_nettype none

module irq_pc_sampling_watchdog_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ipsw_pkg::*;

    localparam int RING_DEPTH  = 16;
    localparam int CLK_HALF    = 10;
    localparam int MAX_CYCLES  = 600000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 142;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [1:0]     cfg_index;
    logic [31:0]    cfg_data;
    logic           s_tvalid;
    logic           s_tready;
    logic [71:0]    s_tdata;
    logic [1:0]     s_tuser;
    logic           m_tvalid;
    logic           m_tready;
    logic [263:0]   m_tdata;
    int             fail_count, outstanding, checked;
    bit             tx_calm, rx_calm;
    int             n_irq_sent, n_timer_sent, n_clear_sent, n_read_sent, n_idle_codes;
    int             n_cfg_writes, cycle_count;

    always #(CLK_HALF) clk = ~clk;

    irq_pc_sampling_watchdog #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    irq_pc_sampling_watchdog_chk #(
        .RING_DEPTH (RING_DEPTH)
    ) u_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    // mostly zero, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return 0;
        end else if (r < 96) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [31:0] ack,
                             input logic [31:0] pc, input logic [2:0] tctl,
                             input logic [3:0] ridx);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {1'b0, ridx, tctl, pc, ack};
        s_tuser  = act;
        do @(posedge clk); while (!s_tready);
        case (act)
            ACT_IRQ: begin
                n_irq_sent++;
                if (ack[9:0] == ID_TIMER_A || ack[9:0] == ID_TIMER_B) begin
                    n_timer_sent++;
                end
            end
            ACT_CLEAR: n_clear_sent++;
            ACT_READ:  n_read_sent++;
            default:   n_idle_codes++;
        endcase
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        n_cfg_writes++;
    endtask

    initial begin : sink_pacing
        int stall;
        m_tready = 1'b0;
        stall    = 0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end else begin
                m_tready = 1'b1;
                if (!rx_calm) begin
                    stall = pick_gap();
                end
            end
        end
    end

    initial begin : timeout_guard
        for (cycle_count = 0; cycle_count < MAX_CYCLES; cycle_count++) @(posedge clk);
        $display("no progress within %0d cycles", MAX_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int          sent, r;
        logic [1:0]  act;
        logic [9:0]  irq_id;
        logic [31:0] ack, lim, ivl;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_IRQ;
        tx_calm   = 1'b0;
        rx_calm   = 1'b0;
        n_irq_sent = 0; n_timer_sent = 0; n_clear_sent = 0; n_read_sent = 0;
        n_idle_codes = 0; n_cfg_writes = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // reset config: one-shot mode, every interrupt kind, reads and a clear
        send_item(ACT_READ,  32'h0,         32'h0,         3'd0, 4'd0);
        send_item(ACT_IRQ,   32'h0,         32'h0,         3'd0, 4'd0);
        send_item(ACT_IRQ,   32'hffff_fc12, 32'hffff_ffff, 3'd7, 4'hf);
        send_item(ACT_IRQ,   32'h0000_0013, 32'h1234_5678, 3'd5, 4'd0);
        send_item(ACT_IRQ,   32'hffff_ffff, 32'ha5a5_a5a5, 3'd2, 4'd0);
        send_item(ACT_IRQ,   32'h0000_03fe, 32'h5a5a_5a5a, 3'd0, 4'd0);
        send_item(ACT_IRQ,   32'h8000_0401, 32'h8000_0001, 3'd1, 4'd0);
        send_item(ACT_NONE,  32'hffff_ffff, 32'hffff_ffff, 3'd7, 4'hf);
        send_item(ACT_READ,  32'h0,         32'h0,         3'd0, 4'hf);
        send_item(ACT_READ,  32'hffff_ffff, 32'hffff_ffff, 3'd7, 4'd2);
        send_item(ACT_READ,  32'h0,         32'h0,         3'd0, 4'd5);
        send_item(ACT_CLEAR, 32'h0,         32'h0,         3'd0, 4'd0);
        send_item(ACT_READ,  32'h0,         32'h0,         3'd0, 4'd2);
        drain();

        // zero limit fires at once and keeps firing
        write_reg(CFG_MODE, 32'd1);
        write_reg(CFG_LIMIT, 32'd0);
        write_reg(CFG_INTERVAL, 32'hffff_ffff);
        send_item(ACT_IRQ, 32'h0000_0012, 32'h0000_1000, 3'd3, 4'd0);
        send_item(ACT_IRQ, 32'h0000_0013, 32'h0000_1004, 3'd6, 4'd0);
        drain();

        // small budget: re-arm twice, then fire, then stay fired
        write_reg(CFG_LIMIT, 32'd3);
        send_item(ACT_CLEAR, 32'h0, 32'h0, 3'd0, 4'd0);
        repeat (4) send_item(ACT_IRQ, 32'h0000_0012, $urandom(), 3'($urandom()), 4'd0);
        drain();

        write_reg(CFG_LIMIT, 32'hffff_ffff);
        write_reg(CFG_INTERVAL, 32'd1);
        send_item(ACT_IRQ, 32'hffff_fc13, 32'h0000_2000, 3'd4, 4'd0);
        send_item(ACT_IRQ, 32'hffff_fc00, 32'h0000_2004, 3'd0, 4'd0);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            r = $urandom_range(0, 4);
            lim = (r == 0) ? 32'd0 : (r == 1) ? 32'd1 : (r == 2) ? 32'hffff_ffff :
                  (r == 3) ? 32'($urandom_range(2, 12)) : $urandom();
            r = $urandom_range(0, 3);
            ivl = (r == 0) ? 32'd0 : (r == 1) ? 32'hffff_ffff : $urandom();
            write_reg(CFG_MODE, (ph % 4 == 0) ? 32'd0 : 32'd1);
            write_reg(CFG_LIMIT, lim);
            write_reg(CFG_INTERVAL, ivl);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    irq_id = $urandom_range(0, 1) ? ID_TIMER_A : ID_TIMER_B;
                end else if (r < 35) begin
                    irq_id = ID_SGI0;
                end else if (r < 42) begin
                    irq_id = ID_SPURIOUS;
                end else begin
                    irq_id = 10'($urandom_range(0, 1023));
                end
                ack = $urandom();
                ack[9:0] = irq_id;
                r = $urandom_range(0, 99);
                act = (r < 68) ? ACT_IRQ : (r < 71) ? ACT_CLEAR : (r < 94) ? ACT_READ :
                      ACT_NONE;
                send_item(act, ack, $urandom(), 3'($urandom()), 4'($urandom()));
                if (act != ACT_NONE) begin
                    sent++;
                end
            end
            drain();
        end

        tx_calm = 1'b0;
        repeat (8) @(posedge clk);
        $display("covered %0d interrupts (%0d timer), %0d clears, %0d ring reads, %0d unused codes",
                 n_irq_sent, n_timer_sent, n_clear_sent, n_read_sent, n_idle_codes);
        $display("%0d register writes across %0d settings, %0d results compared",
                 n_cfg_writes, PHASES + 4, checked);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
